[rtl/hgpg_pkg.sv]
package hgpg_pkg;

  // Widths fixed by the port definition
  localparam int LEG_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_START_SLOW = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FAST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_END_SLOW   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_FAST   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_MASK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFS_MASK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASK   = 3'd7;

  // Register reset values
  localparam logic [9:0]  RST_START_SLOW = 10'd310;
  localparam logic [9:0]  RST_START_FAST = 10'd360;
  localparam logic [9:0]  RST_END_SLOW   = 10'd140;
  localparam logic [9:0]  RST_END_FAST   = 10'd100;
  localparam logic [11:0] RST_TICKS      = 12'd100;
  localparam logic [5:0]  RST_SIDE_MASK  = 6'd26;
  localparam logic [5:0]  RST_OFFS_MASK  = 6'd22;
  localparam logic [5:0]  RST_INV_MASK   = 6'd48;

  // Arithmetic constants
  localparam logic signed [15:0] ONE_Q14    = 16'sd16384;
  localparam logic [23:0]        HALF_Q24   = 24'h800000;
  localparam logic [23:0]        PHASE_RST  = 24'h400000;
  localparam logic signed [27:0] TURN_Q14   = 28'sd12582912;  // 768 steps in Q.14
  localparam logic [9:0]         STEPS_TURN = 10'd768;
  localparam logic [6:0]         MOTOR_GAIN = 7'd105;
  localparam logic [10:0]        SPEED_CAP  = 11'd1536;
  localparam int                 DIV_STEPS  = 25;  // quotient bits that can be nonzero

  // Datapath commands
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PRE1,
    OP_PRE2,
    OP_DIV,
    OP_PHASE,
    OP_LEG1,
    OP_LEG2,
    OP_LEG3,
    OP_LEG4,
    OP_LEG5,
    OP_EMIT
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LEG_W-1:0] leg;
  } cmd_t;

  typedef struct packed {
    logic out_busy;  // output word still waiting to be taken
  } status_t;

  // Residue mod 3 of an 8-bit value, one bit per step
  function automatic logic [1:0] mod3(input logic [7:0] u);
    logic [1:0] acc;
    logic [2:0] t;
    acc = 2'd0;
    for (int i = 7; i >= 0; i--) begin
      t   = {acc, u[i]};
      acc = (t >= 3'd3) ? 2'(t - 3'd3) : t[1:0];
    end
    return acc;
  endfunction

endpackage

[rtl/hexapod_gait_phase_generator.sv]
// Channel  | Handshake            | Word
// ---------+----------------------+-------------------------------------------------
// in       | in_valid / in_stall  | in_speed_cmd, in_steer_cmd (signed Q2.14)
// out      | out_valid/ out_stall | leg index, node address, drive, target, speed, last
// cfg      | cfg_wr_en            | cfg_index, cfg_wdata (no read-back)
//
// One input word yields NUM_LEGS output words: load, two setup steps, the
// bit-serial phase-advance divider and the phase update, then five datapath
// steps and one output load per leg.
// in_stall is high from acceptance until the last output word is loaded.
// A stalled output word holds; the sequencer waits at the output register.
// rst_n is synchronous; configuration and state registers return to their documented defaults.
module hexapod_gait_phase_generator #(
  parameter int NUM_LEGS           = 6,
  parameter int POSITION_FRAC_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic signed [15:0]              in_speed_cmd,
  input  logic signed [15:0]              in_steer_cmd,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_leg_index,
  output logic [1:0]                      out_node_address,
  output logic                            out_drive_select,
  output logic [9:0]                      out_target_position,
  output logic [10:0]                     out_motor_speed,
  output logic                            out_last_leg,
  input  logic                            cfg_wr_en,
  input  logic [hgpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hgpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  hgpg_pkg::cmd_t    cmd;
  hgpg_pkg::status_t status;

  hgpg_ctrl #(
    .NUM_LEGS (NUM_LEGS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  hgpg_datapath #(
    .NUM_LEGS           (NUM_LEGS),
    .POSITION_FRAC_BITS (POSITION_FRAC_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_speed_cmd        (in_speed_cmd),
    .in_steer_cmd        (in_steer_cmd),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_leg_index       (out_leg_index),
    .out_node_address    (out_node_address),
    .out_drive_select    (out_drive_select),
    .out_target_position (out_target_position),
    .out_motor_speed     (out_motor_speed),
    .out_last_leg        (out_last_leg)
  );

endmodule

[rtl/hgpg_ctrl.sv]
module hgpg_ctrl #(
  parameter int NUM_LEGS = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  hgpg_pkg::status_t status,
  output hgpg_pkg::cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE1,
    ST_PRE2,
    ST_DIV,
    ST_PHASE,
    ST_LEG1,
    ST_LEG2,
    ST_LEG3,
    ST_LEG4,
    ST_LEG5,
    ST_EMIT
  } state_t;

  localparam logic [hgpg_pkg::LEG_W-1:0] LAST_LEG = hgpg_pkg::LEG_W'(NUM_LEGS - 1);
  localparam logic [4:0] DIV_LAST = 5'(hgpg_pkg::DIV_STEPS - 1);

  state_t                      state_r;
  logic [hgpg_pkg::LEG_W-1:0]  leg_r;
  logic [4:0]                  div_cnt_r;

  assign in_stall = (state_r != ST_IDLE);

  // Command decode
  always_comb begin
    cmd.leg = leg_r;
    case (state_r)
      ST_IDLE:  cmd.op = in_valid ? hgpg_pkg::OP_LOAD : hgpg_pkg::OP_NONE;
      ST_PRE1:  cmd.op = hgpg_pkg::OP_PRE1;
      ST_PRE2:  cmd.op = hgpg_pkg::OP_PRE2;
      ST_DIV:   cmd.op = hgpg_pkg::OP_DIV;
      ST_PHASE: cmd.op = hgpg_pkg::OP_PHASE;
      ST_LEG1:  cmd.op = hgpg_pkg::OP_LEG1;
      ST_LEG2:  cmd.op = hgpg_pkg::OP_LEG2;
      ST_LEG3:  cmd.op = hgpg_pkg::OP_LEG3;
      ST_LEG4:  cmd.op = hgpg_pkg::OP_LEG4;
      ST_LEG5:  cmd.op = hgpg_pkg::OP_LEG5;
      ST_EMIT:  cmd.op = status.out_busy ? hgpg_pkg::OP_NONE : hgpg_pkg::OP_EMIT;
      default:  cmd.op = hgpg_pkg::OP_NONE;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      leg_r     <= '0;
      div_cnt_r <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_valid) state_r <= ST_PRE1;
        end
        ST_PRE1: state_r <= ST_PRE2;
        ST_PRE2: begin
          div_cnt_r <= '0;
          state_r   <= ST_DIV;
        end
        ST_DIV: begin
          div_cnt_r <= div_cnt_r + 5'd1;
          if (div_cnt_r == DIV_LAST) state_r <= ST_PHASE;
        end
        ST_PHASE: begin
          leg_r   <= '0;
          state_r <= ST_LEG1;
        end
        ST_LEG1: state_r <= ST_LEG2;
        ST_LEG2: state_r <= ST_LEG3;
        ST_LEG3: state_r <= ST_LEG4;
        ST_LEG4: state_r <= ST_LEG5;
        ST_LEG5: state_r <= ST_EMIT;
        ST_EMIT: begin
          if (!status.out_busy) begin
            if (leg_r == LAST_LEG) begin
              state_r <= ST_IDLE;
            end else begin
              leg_r   <= leg_r + 1'b1;
              state_r <= ST_LEG1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/hgpg_datapath.sv]
module hgpg_datapath #(
  parameter int NUM_LEGS           = 6,
  parameter int POSITION_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hgpg_pkg::cmd_t                      cmd,
  output hgpg_pkg::status_t                   status,
  input  logic                                cfg_wr_en,
  input  logic [hgpg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hgpg_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic signed [15:0]                  in_speed_cmd,
  input  logic signed [15:0]                  in_steer_cmd,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [2:0]                          out_leg_index,
  output logic [1:0]                          out_node_address,
  output logic                                out_drive_select,
  output logic [9:0]                          out_target_position,
  output logic [10:0]                         out_motor_speed,
  output logic                                out_last_leg
);

  localparam int F       = POSITION_FRAC_BITS;
  localparam int POS_W   = 10 + F;
  localparam int IDX_W   = $clog2(NUM_LEGS);
  localparam logic [POS_W:0] FULL_POS = (POS_W + 1)'(768) << F;
  localparam logic [POS_W:0] HALF_POS = (POS_W + 1)'(384) << F;
  localparam logic [hgpg_pkg::LEG_W-1:0] LAST_LEG = hgpg_pkg::LEG_W'(NUM_LEGS - 1);

  // Configuration and state
  logic [9:0]  start_slow_r, start_fast_r, end_slow_r, end_fast_r;
  logic [11:0] ticks_r;
  logic [5:0]  side_mask_r, offs_mask_r, inv_mask_r;
  logic [23:0] gait_r;
  logic [POS_W-1:0] leg_pos_r [NUM_LEGS];
  logic        out_valid_r;

  // Per tick working registers
  logic signed [15:0] s_r, t_r;
  logic [14:0]        as_r, at_r;
  logic signed [27:0] ps_r, pe_r, span_r;
  logic [28:0]        sq_r;
  logic [28:0]        rem_r, dvs_r;
  logic [24:0]        dvd_r, quo_r;

  // Per leg working registers
  logic [22:0]        st_r;
  logic signed [49:0] prod1_r;
  logic signed [51:0] prod2_r;
  logic signed [53:0] q_r;
  logic [POS_W-1:0]   pos_r;
  logic [POS_W-1:0]   dist_r;

  // Output registers
  logic [2:0]  leg_idx_r;
  logic [1:0]  node_r;
  logic        drive_r;
  logic [9:0]  target_r;
  logic [10:0] mspeed_r;
  logic        last_r;

  logic out_take;
  assign out_take      = out_valid_r && !out_stall;
  assign status.out_busy = out_valid_r && out_stall;

  // Input clamp to plus or minus one
  logic signed [15:0] s_clamp, t_clamp;
  always_comb begin
    s_clamp = in_speed_cmd;
    if (in_speed_cmd > hgpg_pkg::ONE_Q14) s_clamp = hgpg_pkg::ONE_Q14;
    if (in_speed_cmd < -hgpg_pkg::ONE_Q14) s_clamp = -hgpg_pkg::ONE_Q14;
    t_clamp = in_steer_cmd;
    if (in_steer_cmd > hgpg_pkg::ONE_Q14) t_clamp = hgpg_pkg::ONE_Q14;
    if (in_steer_cmd < -hgpg_pkg::ONE_Q14) t_clamp = -hgpg_pkg::ONE_Q14;
  end

  // Stance angle interpolation: slow*2^14 + (fast-slow)*s
  logic signed [10:0] dstart, dend;
  logic signed [26:0] mstart, mend;
  assign dstart = $signed({1'b0, start_fast_r}) - $signed({1'b0, start_slow_r});
  assign dend   = $signed({1'b0, end_fast_r}) - $signed({1'b0, end_slow_r});
  assign mstart = dstart * s_r;
  assign mend   = dend * s_r;

  // Phase advance operands
  logic        slow_case;
  logic [11:0] tk;
  logic [16:0] den_a;
  logic [39:0] num;
  logic [28:0] den;
  assign slow_case = (at_r != '0) && ({2'b0, at_r} < {1'b0, as_r, 1'b0});
  assign tk        = (ticks_r == '0) ? 12'd1 : ticks_r;
  assign den_a     = {1'b0, as_r, 1'b0} + {2'b0, at_r};
  assign num       = slow_case ? {sq_r, 11'b0} : {15'b0, as_r, 10'b0};
  assign den       = slow_case ? den_a * tk : {17'b0, tk};

  // One restoring division step
  logic [29:0] trial;
  logic        qbit;
  assign trial = {rem_r, dvd_r[24]};
  assign qbit  = (trial >= {1'b0, dvs_r});

  // Leg phase warp
  logic [7:0]  side_sh, offs_sh, inv_sh;
  logic        right, offs, inv, steer_sel;
  logic [22:0] st;
  logic [24:0] w, m1;
  logic signed [23:0] lp1, lp2;
  logic signed [27:0] xspan;
  assign side_sh   = {2'b00, side_mask_r} >> cmd.leg;
  assign offs_sh   = {2'b00, offs_mask_r} >> cmd.leg;
  assign inv_sh    = {2'b00, inv_mask_r} >> leg_idx_r;
  assign right     = side_sh[0];
  assign offs      = offs_sh[0];
  assign inv       = inv_sh[0];
  assign steer_sel = (right && t_r > 16'sd0) || (!right && t_r < 16'sd0);
  assign st        = steer_sel ? {at_r, 8'b0} : '0;
  assign w         = {1'b0, hgpg_pkg::HALF_Q24} - {1'b0, st, 1'b0};
  assign lp1       = $signed(hgpg_pkg::HALF_Q24 - gait_r - (offs ? hgpg_pkg::HALF_Q24 : 24'h0));
  assign m1        = (lp1 > 24'sd0) ? w : (25'h1000000 - w);
  assign lp2       = $signed(prod1_r[46:23] + {1'b0, st_r});
  assign xspan     = (lp2 > 24'sd0) ? span_r : (hgpg_pkg::TURN_Q14 - span_r);

  // Position on the circle: upper part reduced mod 3, lower bits kept
  logic signed [53:0] qa, qb;
  logic [7:0]         hi_u;
  logic [POS_W-1:0]   pos_nxt;
  assign qa      = {prod2_r[51], prod2_r, 1'b0};
  assign qb      = {{2{pe_r[27]}}, pe_r, 24'b0};
  assign hi_u    = q_r[53:46] + 8'd192;
  assign pos_nxt = {hgpg_pkg::mod3(hi_u), q_r[45:38-F]};

  // Shortest circular distance
  logic [POS_W-1:0] last_pos;
  logic [POS_W:0]   diff, adiff, dist_nxt;
  assign last_pos = leg_pos_r[cmd.leg[IDX_W-1:0]];
  assign diff     = {1'b0, pos_r} - {1'b0, last_pos};
  assign adiff    = diff[POS_W] ? (~diff + 1'b1) : diff;
  assign dist_nxt = (adiff > HALF_POS) ? (FULL_POS - adiff) : adiff;

  // Motor speed and reported angle
  logic [POS_W+6:0] sprod;
  logic [POS_W+6:0] sshift;
  logic [9:0]       ipos;
  assign sprod  = dist_r * hgpg_pkg::MOTOR_GAIN;
  assign sshift = sprod >> F;
  assign ipos   = pos_r[POS_W-1:F];

  // Control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_slow_r <= hgpg_pkg::RST_START_SLOW;
      start_fast_r <= hgpg_pkg::RST_START_FAST;
      end_slow_r   <= hgpg_pkg::RST_END_SLOW;
      end_fast_r   <= hgpg_pkg::RST_END_FAST;
      ticks_r      <= hgpg_pkg::RST_TICKS;
      side_mask_r  <= hgpg_pkg::RST_SIDE_MASK;
      offs_mask_r  <= hgpg_pkg::RST_OFFS_MASK;
      inv_mask_r   <= hgpg_pkg::RST_INV_MASK;
      gait_r       <= hgpg_pkg::PHASE_RST;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_LEGS; i++) leg_pos_r[i] <= '0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          hgpg_pkg::REG_START_SLOW: start_slow_r <= cfg_wdata[9:0];
          hgpg_pkg::REG_START_FAST: start_fast_r <= cfg_wdata[9:0];
          hgpg_pkg::REG_END_SLOW:   end_slow_r   <= cfg_wdata[9:0];
          hgpg_pkg::REG_END_FAST:   end_fast_r   <= cfg_wdata[9:0];
          hgpg_pkg::REG_TICKS:      ticks_r      <= cfg_wdata;
          hgpg_pkg::REG_SIDE_MASK:  side_mask_r  <= cfg_wdata[5:0];
          hgpg_pkg::REG_OFFS_MASK:  offs_mask_r  <= cfg_wdata[5:0];
          hgpg_pkg::REG_INV_MASK:   inv_mask_r   <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (cmd.op == hgpg_pkg::OP_PHASE) begin
        gait_r <= s_r[15] ? (gait_r - quo_r[23:0]) : (gait_r + quo_r[23:0]);
      end
      if (cmd.op == hgpg_pkg::OP_LEG5) leg_pos_r[cmd.leg[IDX_W-1:0]] <= pos_r;
      if (cmd.op == hgpg_pkg::OP_EMIT) out_valid_r <= 1'b1;
      else if (out_take)               out_valid_r <= 1'b0;
    end
  end

  // Working and output registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      hgpg_pkg::OP_LOAD: begin
        s_r  <= s_clamp;
        t_r  <= t_clamp;
        as_r <= s_clamp[15] ? 15'(-s_clamp) : s_clamp[14:0];
        at_r <= t_clamp[15] ? 15'(-t_clamp) : t_clamp[14:0];
      end
      hgpg_pkg::OP_PRE1: begin
        ps_r <= $signed({4'b0, start_slow_r, 14'b0}) + 28'(mstart);
        sq_r <= as_r * as_r;
      end
      hgpg_pkg::OP_PRE2: begin
        pe_r  <= $signed({4'b0, end_slow_r, 14'b0}) + 28'(mend);
        rem_r <= {14'b0, num[39:25]};
        dvd_r <= num[24:0];
        dvs_r <= den;
        quo_r <= '0;
      end
      hgpg_pkg::OP_DIV: begin
        rem_r <= qbit ? 29'(trial - {1'b0, dvs_r}) : trial[28:0];
        dvd_r <= {dvd_r[23:0], 1'b0};
        quo_r <= {quo_r[23:0], qbit};
      end
      hgpg_pkg::OP_PHASE: span_r <= ps_r - pe_r;
      hgpg_pkg::OP_LEG1: begin
        st_r    <= st;
        prod1_r <= lp1 * $signed({1'b0, m1});
      end
      hgpg_pkg::OP_LEG2: prod2_r <= lp2 * xspan;
      hgpg_pkg::OP_LEG3: q_r     <= qa + qb;
      hgpg_pkg::OP_LEG4: pos_r   <= pos_nxt;
      hgpg_pkg::OP_LEG5: dist_r  <= dist_nxt[POS_W-1:0];
      hgpg_pkg::OP_EMIT: begin
        leg_idx_r <= cmd.leg;
        node_r    <= 2'(cmd.leg[2:1] + 2'd1);
        drive_r   <= cmd.leg[0];
        last_r    <= (cmd.leg == LAST_LEG);
        mspeed_r  <= (sshift > (POS_W + 7)'(hgpg_pkg::SPEED_CAP)) ? hgpg_pkg::SPEED_CAP
                                                                  : sshift[10:0];
        target_r  <= ipos;
      end
      default: ;
    endcase
  end

  assign out_valid           = out_valid_r;
  assign out_leg_index       = leg_idx_r;
  assign out_node_address    = node_r;
  assign out_drive_select    = drive_r;
  assign out_target_position = inv ? (hgpg_pkg::STEPS_TURN - target_r) : target_r;
  assign out_motor_speed     = mspeed_r;
  assign out_last_leg        = last_r;

endmodule

[rtl/hgpg_checker.sv]
module hgpg_checker #(
  parameter int NUM_LEGS = 6
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_leg_index,
  input logic [1:0]  out_node_address,
  input logic [9:0]  out_target_position,
  input logic [10:0] out_motor_speed,
  input logic        out_last_leg
);

  // A word is held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_target_position))
    else $error("output word changed under stall");

  // An accepted tick keeps the input side busy for its legs
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after a tick");

  // Last flag marks the final leg only
  a_last_leg: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_leg == (out_leg_index == 3'(NUM_LEGS - 1))))
    else $error("last leg flag mismatch");

  // Speed saturates
  a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_motor_speed <= 11'd1536)
    else $error("motor speed above cap");

  // Board address follows leg index
  a_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_node_address == 2'(out_leg_index[2:1] + 2'd1))
    else $error("node address mismatch");

endmodule

bind hexapod_gait_phase_generator hgpg_checker #(
  .NUM_LEGS (NUM_LEGS)
) u_hgpg_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_leg_index       (out_leg_index),
  .out_node_address    (out_node_address),
  .out_target_position (out_target_position),
  .out_motor_speed     (out_motor_speed),
  .out_last_leg        (out_last_leg)
);
